// ----- src/q2r_pkg.sv -----
// ----------------------------------------------------------------------------
// q2r_pkg: shared types and constants
// Widths, beat structs and pipeline depth for the quaternion to
// rotation matrix core.
// ----------------------------------------------------------------------------
package q2r_pkg;

  // Component and entry width.
  localparam int DATA_W     = 32;
  // Fraction bits of a matrix entry (Q2.29).
  localparam int FRAC_OUT   = DATA_W - 3;
  // Width of one signed component product.
  localparam int PROD_W     = 2 * DATA_W;
  // Signed numerator width, magnitude width and remainder width.
  localparam int NUM_W      = 2 * DATA_W + 2;
  localparam int MAG_W      = 2 * DATA_W + 1;
  localparam int REM_W      = 2 * DATA_W + 2;
  // Quotient bits: one integer bit and the fraction bits.
  localparam int Q_W        = FRAC_OUT + 1;
  localparam int N_ENT      = 9;
  localparam int DIV_STAGES = Q_W;
  // Edges from an accepted start to the done strobe.
  localparam int LATENCY    = DIV_STAGES + 5;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct packed {
    word_t comp_0;
    word_t comp_1;
    word_t comp_2;
    word_t comp_3;
  } quat_t;

  typedef struct packed {
    word_t m00;
    word_t m01;
    word_t m02;
    word_t m10;
    word_t m11;
    word_t m12;
    word_t m20;
    word_t m21;
    word_t m22;
    logic  zero_norm;
  } matrix_t;

  // One beat handed to the divider array.
  typedef struct packed {
    logic                         valid;
    logic                         zero_norm;
    logic [MAG_W-1:0]             s;
    logic [N_ENT-1:0]             neg;
    logic [N_ENT-1:0][MAG_W-1:0]  mag;
  } div_in_t;

  // One beat leaving the divider array.
  typedef struct packed {
    logic                         valid;
    logic                         zero_norm;
    logic [N_ENT-1:0]             neg;
    logic [N_ENT-1:0][Q_W-1:0]    quo;
  } div_out_t;

endpackage

// ----- src/q2r_divider.sv -----
// ----------------------------------------------------------------------------
// q2r_divider: pipelined restoring divider array
// Nine lanes share one divisor; each stage resolves one quotient bit
// of every lane with one compare and subtract.
// ----------------------------------------------------------------------------
module q2r_divider (
  input  logic               clk,
  input  logic               rst,
  input  q2r_pkg::div_in_t   din,
  output q2r_pkg::div_out_t  dout
);
  import q2r_pkg::*;

  typedef struct packed {
    logic                         valid;
    logic                         zero_norm;
    logic [MAG_W-1:0]             s;
    logic [N_ENT-1:0]             neg;
    logic [N_ENT-1:0][REM_W-1:0]  rem;
    logic [N_ENT-1:0][Q_W-1:0]    quo;
  } stage_t;

  stage_t st      [DIV_STAGES];
  stage_t st_next [DIV_STAGES];

  genvar g;
  generate
    for (g = 0; g < DIV_STAGES; g++) begin : g_stage
      stage_t                       src;
      logic [N_ENT-1:0][REM_W-1:0]  cand;

      // The first stage takes the magnitudes as they are; later stages
      // shift the partial remainder left by one.
      if (g == 0) begin : g_first
        always_comb begin
          src.valid     = din.valid;
          src.zero_norm = din.zero_norm;
          src.s         = din.s;
          src.neg       = din.neg;
          for (int i = 0; i < N_ENT; i++) begin
            src.rem[i] = REM_W'(din.mag[i]);
            src.quo[i] = '0;
          end
          cand = src.rem;
        end
      end else begin : g_rest
        always_comb begin
          src = st[g-1];
          for (int i = 0; i < N_ENT; i++) begin
            cand[i] = {src.rem[i][REM_W-2:0], 1'b0};
          end
        end
      end

      // One quotient bit per lane.
      always_comb begin
        st_next[g] = src;
        for (int i = 0; i < N_ENT; i++) begin
          if (cand[i] >= REM_W'(src.s)) begin
            st_next[g].rem[i] = cand[i] - REM_W'(src.s);
            st_next[g].quo[i] = {src.quo[i][Q_W-2:0], 1'b1};
          end else begin
            st_next[g].rem[i] = cand[i];
            st_next[g].quo[i] = {src.quo[i][Q_W-2:0], 1'b0};
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          st[g] <= '0;
        end else begin
          st[g] <= st_next[g];
        end
      end
    end
  endgenerate

  assign dout.valid     = st[DIV_STAGES-1].valid;
  assign dout.zero_norm = st[DIV_STAGES-1].zero_norm;
  assign dout.neg       = st[DIV_STAGES-1].neg;
  assign dout.quo       = st[DIV_STAGES-1].quo;

endmodule

// ----- src/quaternion_to_rotation_matrix_core.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_core: quaternion to rotation matrix
// Turns one Q1.30 quaternion into a normalized 3x3 Q2.29 matrix.
// ----------------------------------------------------------------------------
// Usage:
//   A quaternion beat is taken on quat at each rising edge where start is
//   high and busy is low. busy is always low: the core takes one beat
//   every cycle. comp_2 is treated as the scalar part.
//   Each result beat appears on result for exactly one cycle, marked by
//   done, in input order.
//   The pipeline is the input, product, sum and magnitude registers, the
//   divider array of 30 stages with one quotient bit per stage, and the
//   output register. Throughput is one beat per cycle.
//   A zero quaternion gives zero entries with zero_norm set.
//   Entries are divided by the squared norm and truncated toward zero.
//   Synchronous reset drops every beat in flight; done stays low until
//   new beats arrive. The receiver cannot stall the output.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  q2r_pkg::quat_t    quat,
  output logic              done,
  output q2r_pkg::matrix_t  result
);
  import q2r_pkg::*;

  // Stage 1: reordered components.
  logic  v1;
  word_t q [4];

  // Stage 2: the ten signed products.
  logic                     v2;
  logic signed [PROD_W-1:0] p00, p11, p22, p33, p01, p02, p03, p12, p13, p23;

  // Stage 3: numerators and squared norm.
  logic                     v3;
  logic signed [NUM_W-1:0]  num [N_ENT];
  logic [MAG_W-1:0]         s3;

  // Stage 4 and divider.
  div_in_t                  din;
  div_in_t                  din_next;
  div_out_t                 dout;

  logic signed [NUM_W-1:0]  sq0, sq1, sq2, sq3, ssum;
  logic signed [NUM_W-1:0]  x01, x02, x03, x12, x13, x23;

  assign busy = 1'b0;

  // Input register, comp_3 moved to front.
  always_ff @(posedge clk) begin
    q[0] <= quat.comp_3;
    q[1] <= quat.comp_0;
    q[2] <= quat.comp_1;
    q[3] <= quat.comp_2;
    v1   <= rst ? 1'b0 : start;
  end

  // Product register.
  always_ff @(posedge clk) begin
    p00 <= q[0] * q[0];
    p11 <= q[1] * q[1];
    p22 <= q[2] * q[2];
    p33 <= q[3] * q[3];
    p01 <= q[0] * q[1];
    p02 <= q[0] * q[2];
    p03 <= q[0] * q[3];
    p12 <= q[1] * q[2];
    p13 <= q[1] * q[3];
    p23 <= q[2] * q[3];
    v2  <= rst ? 1'b0 : v1;
  end

  // Extend the products to numerator width.
  always_comb begin
    sq0  = NUM_W'(p00);
    sq1  = NUM_W'(p11);
    sq2  = NUM_W'(p22);
    sq3  = NUM_W'(p33);
    x01  = NUM_W'(p01);
    x02  = NUM_W'(p02);
    x03  = NUM_W'(p03);
    x12  = NUM_W'(p12);
    x13  = NUM_W'(p13);
    x23  = NUM_W'(p23);
    ssum = (sq0 + sq1) + (sq2 + sq3);
  end

  // Numerator register.
  always_ff @(posedge clk) begin
    num[0] <= (sq0 + sq3) - (sq1 + sq2);
    num[1] <= (x01 - x23) <<< 1;
    num[2] <= (x02 + x13) <<< 1;
    num[3] <= (x01 + x23) <<< 1;
    num[4] <= (sq1 + sq3) - (sq0 + sq2);
    num[5] <= (x12 - x03) <<< 1;
    num[6] <= (x02 - x13) <<< 1;
    num[7] <= (x12 + x03) <<< 1;
    num[8] <= (sq2 + sq3) - (sq0 + sq1);
    s3     <= ssum[MAG_W-1:0];
    v3     <= rst ? 1'b0 : v2;
  end

  // Signs and magnitudes for the divider.
  always_comb begin
    logic signed [NUM_W-1:0] a;
    din_next.valid     = v3;
    din_next.zero_norm = (s3 == '0);
    din_next.s         = s3;
    for (int i = 0; i < N_ENT; i++) begin
      a                  = num[i][NUM_W-1] ? -num[i] : num[i];
      din_next.neg[i]    = num[i][NUM_W-1];
      din_next.mag[i]    = a[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      din <= '0;
    end else begin
      din <= din_next;
    end
  end

  q2r_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout)
  );

  // Apply signs and force zeros for a zero quaternion.
  word_t ent [N_ENT];
  always_comb begin
    word_t mq;
    for (int i = 0; i < N_ENT; i++) begin
      mq     = word_t'(dout.quo[i]);
      ent[i] = dout.zero_norm ? '0 : (dout.neg[i] ? -mq : mq);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    result.m00       <= ent[0];
    result.m01       <= ent[1];
    result.m02       <= ent[2];
    result.m10       <= ent[3];
    result.m11       <= ent[4];
    result.m12       <= ent[5];
    result.m20       <= ent[6];
    result.m21       <= ent[7];
    result.m22       <= ent[8];
    result.zero_norm <= dout.zero_norm;
    done             <= rst ? 1'b0 : dout.valid;
  end

endmodule

// ----- src/q2r_checker.sv -----
// ----------------------------------------------------------------------------
// q2r_checker: port level checks
// Watches the core's ports for latency, zero handling and entry range.
// ----------------------------------------------------------------------------
module q2r_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input q2r_pkg::quat_t    quat,
  input logic              done,
  input q2r_pkg::matrix_t  result
);
  import q2r_pkg::*;

  localparam word_t ONE = word_t'(1) <<< FRAC_OUT;

  // Every result beat traces back to an accepted start beat.
  a_done_has_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("done without a matching start beat");

  // A flagged zero quaternion gives zero m00, m11, m22, m01 and m12.
  a_zero_entries: assert property (@(posedge clk) disable iff (rst)
    (done && result.zero_norm) |-> (result.m00 == '0 && result.m11 == '0 &&
      result.m22 == '0 && result.m01 == '0 && result.m12 == '0))
    else $error("zero_norm with nonzero entries");

  // Diagonal entries m00 and m11 never exceed one in magnitude.
  a_diag_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.m00 <= ONE && result.m00 >= -ONE &&
      result.m11 <= ONE && result.m11 >= -ONE))
    else $error("diagonal entry out of range");

  // A zero input quaternion is flagged.
  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    (done && $past(quat == '0, LATENCY)) |-> result.zero_norm)
    else $error("zero quaternion not flagged");

endmodule

bind quaternion_to_rotation_matrix_core q2r_checker u_q2r_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .quat   (quat),
  .done   (done),
  .result (result)
);
